// File: hdl/msp_pkg.sv
// shared types and constants for the spatial pooling block
`default_nettype none
package msp_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned VAL_W       = FRAC_BITS + 1;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned IN_TDATA_W  = ((VAL_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((VAL_W + POS_W + 1 + 7) / 8) * 8;

  localparam logic [VAL_W-1:0] ONE_FX = VAL_W'(1) << FRAC_BITS;

  localparam logic [MODE_W-1:0] MODE_MAX    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NOR    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAXNOR = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] prob;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             overrun;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] pooled;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/mil_spatial_pooling.sv
// result path: the map's closing item passes through the input register and then the result register
// throughput: one item per cycle while no closing item is held; the state update is one 17x17 multiply and one compare
// a closing item waits in the input register only while the result register is full and not being read
// reset: asynchronous active low; clears pool_mode to max, the map state and both valids
`default_nettype none
module mil_spatial_pooling #(
  parameter int unsigned MAX_POSITIONS = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              pool_mode_we_i,
  input  wire logic [msp_pkg::MODE_W-1:0]        pool_mode_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [16:0] prob_in, rest zero
  input  wire logic [msp_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  wire logic                              s_axis_tlast_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [16:0] pooled_value, [28:17] best_position, [29] overrun, rest zero
  output logic [msp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o
);

  logic [msp_pkg::MODE_W-1:0] mode_q;
  logic                       in_valid;
  msp_pkg::item_t             in_item;
  msp_pkg::result_t           result;
  logic                       out_free;
  logic                       adv;
  logic                       load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= msp_pkg::MODE_MAX;
    end else if (pool_mode_we_i) begin
      mode_q <= pool_mode_i;
    end
  end

  // a closing item moves on only when the result register can take it
  assign adv  = in_valid && (!in_item.last || out_free);
  assign load = adv && in_item.last;

  msp_in_reg u_in (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .s_axis_tready_o(s_axis_tready_o),
    .adv_i          (adv),
    .valid_o        (in_valid),
    .item_o         (in_item)
  );

  msp_pool_core #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .item_i  (in_item),
    .mode_i  (mode_q),
    .result_o(result)
  );

  msp_out_reg u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .result_i       (result),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .free_o         (out_free)
  );

  a_result_from_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(load))
    else $error("result appeared without a closing item");

  a_pooled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[msp_pkg::VAL_W-1:0] <= msp_pkg::ONE_FX))
    else $error("pooled value above one");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !adv) |=> in_valid)
    else $error("stalled input item dropped");

endmodule
`default_nettype wire

// File: hdl/msp_in_reg.sv
// input register with saturation of the probability to one
`default_nettype none
module msp_in_reg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  input  wire logic [msp_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  wire logic                              s_axis_tlast_i,
  output logic                                   s_axis_tready_o,
  input  wire logic                              adv_i,
  output logic                                   valid_o,
  output msp_pkg::item_t                         item_o
);

  logic                          valid_q, valid_d;
  msp_pkg::item_t                item_q, item_d;
  logic [msp_pkg::VAL_W-1:0]     prob_raw;
  logic                          take;

  assign prob_raw        = s_axis_tdata_i[msp_pkg::VAL_W-1:0];
  assign s_axis_tready_o = !valid_q || adv_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    item_d.prob = (prob_raw > msp_pkg::ONE_FX) ? msp_pkg::ONE_FX : prob_raw;
    item_d.last = s_axis_tlast_i;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// File: hdl/msp_pool_core.sv
// map state: running product, first maximum, position counter, result forming
`default_nettype none
module msp_pool_core #(
  parameter int unsigned MAX_POSITIONS = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire msp_pkg::item_t                item_i,
  input  wire logic [msp_pkg::MODE_W-1:0]    mode_i,
  output msp_pkg::result_t                   result_o
);

  localparam int unsigned CW = $clog2(MAX_POSITIONS + 1);
  localparam int unsigned VW = msp_pkg::VAL_W;

  logic [VW-1:0]             prod_q, prod_d, prod_new;
  logic [VW-1:0]             best_q, best_d, best_new;
  logic [msp_pkg::POS_W-1:0] idx_q, idx_d, idx_new;
  logic [CW-1:0]             cnt_q, cnt_d, cnt_new;
  logic                      have_q, have_d;
  logic                      ovr_q, ovr_d, ovr_new;
  logic                      in_range;
  logic [CW-1:0]             pos;
  logic [VW-1:0]             one_minus;
  logic [2*VW-1:0]           mul;
  logic [VW-1:0]             noisy;
  logic                      take_max;

  always_comb begin
    in_range  = cnt_q < CW'(MAX_POSITIONS);
    pos       = in_range ? cnt_q : CW'(MAX_POSITIONS - 1);
    cnt_new   = in_range ? cnt_q + CW'(1) : cnt_q;
    ovr_new   = ovr_q || !in_range;

    one_minus = msp_pkg::ONE_FX - item_i.prob;
    mul       = prod_q * one_minus;
    // product stays at or below one, so the upper bits after the shift are zero
    prod_new  = mul[msp_pkg::FRAC_BITS +: VW];

    // ties keep the earlier position
    take_max  = !have_q || (item_i.prob > best_q);
    best_new  = take_max ? item_i.prob : best_q;
    idx_new   = take_max ? msp_pkg::POS_W'(pos) : idx_q;

    noisy     = msp_pkg::ONE_FX - prod_new;
    unique case (mode_i)
      msp_pkg::MODE_MAX: result_o.pooled = best_new;
      msp_pkg::MODE_NOR: result_o.pooled = noisy;
      default:           result_o.pooled = (noisy > best_new) ? noisy : best_new;
    endcase
    result_o.position = idx_new;
    result_o.overrun  = ovr_new;

    prod_d = prod_q;
    best_d = best_q;
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    have_d = have_q;
    ovr_d  = ovr_q;
    if (adv_i) begin
      if (item_i.last) begin
        prod_d = msp_pkg::ONE_FX;
        best_d = '0;
        idx_d  = '0;
        cnt_d  = '0;
        have_d = 1'b0;
        ovr_d  = 1'b0;
      end else begin
        prod_d = prod_new;
        best_d = best_new;
        idx_d  = idx_new;
        cnt_d  = cnt_new;
        have_d = 1'b1;
        ovr_d  = ovr_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= msp_pkg::ONE_FX;
      best_q <= '0;
      idx_q  <= '0;
      cnt_q  <= '0;
      have_q <= 1'b0;
      ovr_q  <= 1'b0;
    end else begin
      prod_q <= prod_d;
      best_q <= best_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      have_q <= have_d;
      ovr_q  <= ovr_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/msp_out_reg.sv
// result register toward the master side
`default_nettype none
module msp_out_reg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              load_i,
  input  wire msp_pkg::result_t                  result_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic [msp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  output logic                                   free_o
);

  logic             valid_q, valid_d;
  msp_pkg::result_t data_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = msp_pkg::OUT_TDATA_W'(data_q);

endmodule
`default_nettype wire
